// ===== hdl/p2cd_pkg.sv =====
// Package for the polar to cartesian (degrees) CORDIC core.
// Holds the angle constants, datapath widths and the arctangent and gain tables.
// No dependencies.
`timescale 1ns / 1ps

package p2cd_pkg;

	// angle units are 1/128 degree
	localparam int FULL_TURN    = 46080;
	localparam int QUARTER_TURN = 11520;
	localparam int HALF_TURN    = 23040;
	localparam int THREE_QTR    = 34560;

	localparam int DW = 48;   // x/y datapath, units of 2^-38
	localparam int ZW = 32;   // residual angle, units of 2^-22 degree

	localparam int MIN_STAGES = 8;
	localparam int MAX_STAGES = 24;

	typedef enum logic [1:0] {
		QUAD_0,
		QUAD_1,
		QUAD_2,
		QUAD_3
	} quad_t;

	// atan(2^-i) in degrees, scaled by 2^22
	localparam logic [27:0] ATAN_Q22 [MAX_STAGES] = '{
		28'd188743680, 28'd111421900, 28'd58872272, 28'd29884485,
		28'd15000234,  28'd7507429,   28'd3754631,  28'd1877430,
		28'd938729,    28'd469366,    28'd234683,   28'd117342,
		28'd58671,     28'd29335,     28'd14668,    28'd7334,
		28'd3667,      28'd1833,      28'd917,      28'd458,
		28'd229,       28'd115,       28'd57,       28'd29
	};

	// CORDIC gain compensation, Q30, for 8 .. 24 stages
	localparam logic [29:0] GAIN_Q30 [MAX_STAGES - MIN_STAGES + 1] = '{
		30'd652039507, 30'd652034532, 30'd652033289, 30'd652032978,
		30'd652032900, 30'd652032881, 30'd652032876, 30'd652032874,
		30'd652032874, 30'd652032874, 30'd652032874, 30'd652032874,
		30'd652032874, 30'd652032874, 30'd652032874, 30'd652032874,
		30'd652032874
	};

endpackage

// ===== hdl/polar_to_cartesian_degrees_core.sv =====
// Polar to cartesian conversion, angle in degrees, by pipelined CORDIC rotation.
// Depends on p2cd_pkg.
`timescale 1ns / 1ps

// Usage
//  Input request (s_*): s_tdata carries magnitude (signed Q8.8) and angle_deg
//  (signed, 1/128 degree). A request is taken on a clock edge with s_tvalid and
//  s_tready both high.
//  Output request (m_*): m_tdata carries x_component = magnitude*cos(angle) and
//  y_component = magnitude*sin(angle), signed Q8.8, rounded half up, saturated.
//  One output request per input request, in order.
//  Pipeline: NSTAGES + 4 register stages, NSTAGES being CORDIC_STAGES clamped to
//  8..24: angle wrap plus gain multiply, quadrant split, one per rotation stage,
//  quadrant mapping, rounding/saturation.
//  Throughput: one request per cycle, set by the fully unrolled rotation chain.
//  Every stage carries its own valid bit and loads whenever it is empty or the
//  stage after it moves, so bubbles close up and input keeps flowing while a
//  result waits on m_tready. Only when every stage holds a request does
//  s_tready fall. A stall loses and repeats nothing.
//  Reset (arst_n low) empties the pipeline; the block holds no other state.
//  Angles outside +/-360 degrees are wrapped modulo 360.

module polar_to_cartesian_degrees_core #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// slave side
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [15:0] magnitude, [32:16] angle_deg, [39:33] zero
	// master side
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // [15:0] x_component, [31:16] y_component
);

	import p2cd_pkg::*;

	localparam int NSTAGES = (CORDIC_STAGES < MIN_STAGES) ? MIN_STAGES :
	                         ((CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES);
	localparam logic [29:0] GAIN = GAIN_Q30[NSTAGES - MIN_STAGES];

	// ---------------------------------------------------------------
	// input fields
	// ---------------------------------------------------------------
	logic signed [15:0] mag_in;
	logic signed [16:0] ang_in;
	logic signed [18:0] ang_w;
	logic        [15:0] ang_norm;

	assign mag_in = s_tdata[15:0];
	assign ang_in = s_tdata[32:16];
	assign ang_w  = 19'(ang_in);

	// wrap into [0, 360) degrees: the 17-bit range needs at most two turns
	always_comb begin
		if (ang_w < -19'sd46080)
			ang_norm = 16'(ang_w + 19'sd92160);
		else if (ang_w < 19'sd0)
			ang_norm = 16'(ang_w + 19'sd46080);
		else if (ang_w >= 19'(FULL_TURN))
			ang_norm = 16'(ang_w - 19'sd46080);
		else
			ang_norm = 16'(ang_w);
	end

	// ---------------------------------------------------------------
	// flow control: a stage loads when empty or when the next one moves
	// ---------------------------------------------------------------
	logic vld_s1, vld_sm, vld_so;
	logic adv_s1, adv_sm, adv_so;
	logic rot_v_s   [0:NSTAGES];   // index 0 is stage 2 (quadrant split)
	logic adv_rot   [0:NSTAGES];

	assign adv_so   = !vld_so || m_tready;
	assign adv_sm   = !vld_sm || adv_so;
	assign adv_rot[NSTAGES] = !rot_v_s[NSTAGES] || adv_sm;
	assign adv_s1   = !vld_s1 || adv_rot[0];
	assign s_tready = adv_s1;

	// ---------------------------------------------------------------
	// stage 1: wrapped angle, magnitude times gain compensation
	// ---------------------------------------------------------------
	logic signed [DW-1:0] x_s1;
	logic        [15:0]   ang_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv_s1) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			x_s1   <= DW'(mag_in * $signed({1'b0, GAIN}));
			ang_s1 <= ang_norm;
		end
	end

	// ---------------------------------------------------------------
	// stage 2: quadrant and remainder, remainder scaled into z
	// ---------------------------------------------------------------
	logic signed [DW-1:0] rot_x_s [0:NSTAGES];
	logic signed [DW-1:0] rot_y_s [0:NSTAGES];
	logic signed [ZW-1:0] rot_z_s [0:NSTAGES];
	quad_t                rot_q_s [0:NSTAGES];

	quad_t       quad_c;
	logic [13:0] rem_c;

	always_comb begin
		if (ang_s1 < 16'(QUARTER_TURN)) begin
			quad_c = QUAD_0;
			rem_c  = 14'(ang_s1);
		end else if (ang_s1 < 16'(HALF_TURN)) begin
			quad_c = QUAD_1;
			rem_c  = 14'(ang_s1 - 16'(QUARTER_TURN));
		end else if (ang_s1 < 16'(THREE_QTR)) begin
			quad_c = QUAD_2;
			rem_c  = 14'(ang_s1 - 16'(HALF_TURN));
		end else begin
			quad_c = QUAD_3;
			rem_c  = 14'(ang_s1 - 16'(THREE_QTR));
		end
	end

	assign adv_rot[0] = !rot_v_s[0] || adv_rot[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_v_s[0] <= 1'b0;
		end else if (adv_rot[0]) begin
			rot_v_s[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_rot[0]) begin
			rot_x_s[0] <= x_s1;
			rot_y_s[0] <= '0;
			rot_z_s[0] <= $signed({3'b000, rem_c, 15'd0});
			rot_q_s[0] <= quad_c;
		end
	end

	// ---------------------------------------------------------------
	// rotation stages: turn toward the residual angle
	// ---------------------------------------------------------------
	for (genvar k = 0; k < NSTAGES; k++) begin : g_rot
		logic signed [ZW-1:0] atan_k;
		logic signed [DW-1:0] dx, dy;

		assign atan_k = $signed({4'b0000, ATAN_Q22[k]});
		assign dx     = rot_y_s[k] >>> k;
		assign dy     = rot_x_s[k] >>> k;

		if (k < NSTAGES - 1) begin : g_adv
			assign adv_rot[k+1] = !rot_v_s[k+1] || adv_rot[k+2];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rot_v_s[k+1] <= 1'b0;
			end else if (adv_rot[k+1]) begin
				rot_v_s[k+1] <= rot_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv_rot[k+1]) begin
				rot_q_s[k+1] <= rot_q_s[k];
				if (!rot_z_s[k][ZW-1]) begin
					rot_x_s[k+1] <= rot_x_s[k] - dx;
					rot_y_s[k+1] <= rot_y_s[k] + dy;
					rot_z_s[k+1] <= rot_z_s[k] - atan_k;
				end else begin
					rot_x_s[k+1] <= rot_x_s[k] + dx;
					rot_y_s[k+1] <= rot_y_s[k] - dy;
					rot_z_s[k+1] <= rot_z_s[k] + atan_k;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// quadrant mapping: swap and negate cos/sin
	// ---------------------------------------------------------------
	logic signed [DW-1:0] rx_c, ry_c, rx_sm, ry_sm;

	always_comb begin
		case (rot_q_s[NSTAGES])
			QUAD_0: begin
				rx_c = rot_x_s[NSTAGES];
				ry_c = rot_y_s[NSTAGES];
			end
			QUAD_1: begin
				rx_c = -rot_y_s[NSTAGES];
				ry_c = rot_x_s[NSTAGES];
			end
			QUAD_2: begin
				rx_c = -rot_x_s[NSTAGES];
				ry_c = -rot_y_s[NSTAGES];
			end
			default: begin
				rx_c = rot_y_s[NSTAGES];
				ry_c = -rot_x_s[NSTAGES];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sm <= 1'b0;
		end else if (adv_sm) begin
			vld_sm <= rot_v_s[NSTAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (adv_sm) begin
			rx_sm <= rx_c;
			ry_sm <= ry_c;
		end
	end

	// ---------------------------------------------------------------
	// output: round half up to Q8.8 and saturate
	// ---------------------------------------------------------------
	function automatic logic [15:0] round_sat(input logic signed [DW-1:0] v);
		logic signed [DW-1:0] t;
		logic signed [17:0]   r;
		t = v + DW'(64'sd536870912);
		r = t[47:30];
		if (r > 18'sd32767)
			return 16'h7FFF;
		else if (r < -18'sd32768)
			return 16'h8000;
		else
			return r[15:0];
	endfunction

	logic [15:0] x_so, y_so;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_so <= 1'b0;
		end else if (adv_so) begin
			vld_so <= vld_sm;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_so) begin
			x_so <= round_sat(rx_sm);
			y_so <= round_sat(ry_sm);
		end
	end

	assign m_tvalid = vld_so;
	assign m_tdata  = {y_so, x_so};

	// ---------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------
`ifndef NO_ASSERTIONS
	// input only backs up once every stage holds a request
	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (vld_s1 && rot_v_s[0] && rot_v_s[NSTAGES] && vld_sm && vld_so))
		else $error("s_tready low with an empty stage");

	// angle wrap lands inside one turn
	a_wrap_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (ang_s1 < 16'(FULL_TURN)))
		else $error("wrapped angle out of range");

	// remainder entering the rotator stays below a quarter turn
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		rot_v_s[0] |-> (rot_z_s[0] >= 0 && rot_z_s[0] < $signed(ZW'(QUARTER_TURN * 32768))))
		else $error("quadrant remainder out of range");
`endif

endmodule

// ===== tb/tb_polar_to_cartesian_degrees_core.sv =====
// Self-checking bench for polar_to_cartesian_degrees_core: a directed table, then random
// requests under varying back-pressure, checked against a CORDIC predictor in the bench.
// Depends on p2cd_pkg and the core itself.
`timescale 1ns / 1ps

module tb_polar_to_cartesian_degrees_core;

	import p2cd_pkg::*;

	localparam int STAGES      = 16;
	localparam int LATENCY     = STAGES + 4;
	localparam int HOLD_CYCLES = 300;    // long receiver hold-off, fills the pipeline
	localparam int STALL_LIMIT = 3000;   // cycles with no transfer on either side
	localparam int PHASE_ITEMS = 200;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
	} xy_t;

	typedef struct packed {
		logic signed [15:0] mag;
		logic signed [16:0] ang;
		bit                 typed;   // expected x/y given below, else predicted
		logic signed [15:0] x;
		logic signed [15:0] y;
	} directed_row_t;

	// atan(2^-i) in degrees, times 2^22
	localparam longint ATAN_DEG_Q22 [24] = '{
		188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
		3754631, 1877430, 938729, 469366, 234683, 117342,
		58671, 29335, 14668, 7334, 3667, 1833,
		917, 458, 229, 115, 57, 29
	};

	// gain compensation, Q30, indexed by stage count - 8
	localparam longint GAIN_COMP_Q30 [17] = '{
		652039507, 652034532, 652033289, 652032978, 652032900, 652032881,
		652032876, 652032874, 652032874, 652032874, 652032874, 652032874,
		652032874, 652032874, 652032874, 652032874, 652032874
	};

	// angles in 1/128 degree; quadrant edges, wrap points, field extremes
	directed_row_t directed_rows [23] = '{
		'{0,      0,      1'b1, 0,   0},
		'{0,      -65536, 1'b1, 0,   0},
		'{256,    -46080, 1'b1, 256, 0},   // -360 deg folds to 0
		'{256,    0,      1'b1, 256, 0},
		'{32767,  0,      1'b0, 0,   0},
		'{-32768, 0,      1'b0, 0,   0},   // most negative magnitude
		'{-32768, 11520,  1'b0, 0,   0},
		'{-32768, 23040,  1'b0, 0,   0},
		'{-32768, 34560,  1'b0, 0,   0},
		'{32767,  46079,  1'b0, 0,   0},
		'{32767,  46080,  1'b0, 0,   0},   // one full turn, outside nominal range
		'{-32768, 65535,  1'b0, 0,   0},
		'{32767,  -65536, 1'b0, 0,   0},
		'{12345,  -11520, 1'b0, 0,   0},
		'{12345,  -23040, 1'b0, 0,   0},
		'{12345,  -34560, 1'b0, 0,   0},
		'{-20000, -46081, 1'b0, 0,   0},
		'{25600,  5760,   1'b0, 0,   0},
		'{25600,  11519,  1'b0, 0,   0},
		'{-1,     17000,  1'b0, 0,   0},
		'{1,      -1,     1'b0, 0,   0},
		'{21845,  43690,  1'b0, 0,   0},   // alternating bit patterns
		'{-21846, -43691, 1'b0, 0,   0}
	};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;

	xy_t pending_xy [$];
	xy_t oldest_xy;
	int  mismatches;
	int  results_seen;
	int  idle_cycles;
	int  send_idle_pct;
	int  recv_idle_pct;
	bit  hold_req;

	polar_to_cartesian_degrees_core #(
		.CORDIC_STAGES(STAGES)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic signed [15:0] round_to_q8_8(input longint v);
		longint r;
		r = (v + (64'sd1 <<< 29)) >>> 30;
		if (r > 32767)
			r = 32767;
		if (r < -32768)
			r = -32768;
		return r[15:0];
	endfunction

	// quadrant fold, CORDIC rotation of (mag*K, 0), then quadrant remap
	function automatic xy_t polar_to_xy(input logic signed [15:0] mag,
			input logic signed [16:0] ang);
		longint a, x, y, z, dx, dy, rx, ry;
		int     n;
		quad_t  quad;
		xy_t    res;
		n = (STAGES < MIN_STAGES) ? MIN_STAGES : (STAGES > MAX_STAGES) ? MAX_STAGES : STAGES;
		a = ang;
		a = a % FULL_TURN;
		if (a < 0)
			a += FULL_TURN;
		quad = quad_t'(a / QUARTER_TURN);
		z = (a % QUARTER_TURN) * 32768;
		x = mag;
		x = x * GAIN_COMP_Q30[n - MIN_STAGES];
		y = 0;
		for (int i = 0; i < n; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= ATAN_DEG_Q22[i];
			end else begin
				x += dx;
				y -= dy;
				z += ATAN_DEG_Q22[i];
			end
		end
		case (quad)
			QUAD_0: begin
				rx = x;
				ry = y;
			end
			QUAD_1: begin
				rx = -y;
				ry = x;
			end
			QUAD_2: begin
				rx = -x;
				ry = -y;
			end
			default: begin
				rx = y;
				ry = -x;
			end
		endcase
		res.x = round_to_q8_8(rx);
		res.y = round_to_q8_8(ry);
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: result %0d %s: got %0d, expected %0d", $realtime, results_seen, what,
				got, want);
		mismatches++;
	endtask

	// Entered and left at a falling edge. Valid stays high between back-to-back requests.
	task automatic offer_request(input logic signed [15:0] mag, input logic signed [16:0] ang,
			input xy_t want);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'b0, ang, mag};
		do
			@(posedge clk);
		while (!s_tready);
		pending_xy.push_back(want);
		@(negedge clk);
	endtask

	function automatic logic signed [15:0] pick_magnitude();
		int sel;
		sel = $urandom_range(99);
		if (sel < 10) begin
			case ($urandom_range(4))
				0: return 16'sh8000;
				1: return 16'sh7fff;
				2: return 16'sh0000;
				3: return 16'shffff;
				default: return 16'sh0001;
			endcase
		end
		if (sel < 25)
			return 16'($urandom_range(1023) - 512);
		return 16'($urandom());
	endfunction

	function automatic logic signed [16:0] pick_angle();
		int sel;
		int k;
		sel = $urandom_range(99);
		if (sel < 20)
			return 17'($urandom());   // any 17-bit pattern, wraps included
		if (sel < 40) begin
			k = $urandom_range(7);
			return 17'((k - 4) * QUARTER_TURN + $urandom_range(6) - 3);
		end
		return 17'($urandom_range(2 * FULL_TURN - 1) - FULL_TURN);
	endfunction

	// results, checked at the rising edge
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_xy.size() == 0) begin
				report_mismatch("arrived with nothing pending", $signed(m_tdata[15:0]), 0);
			end else begin
				oldest_xy = pending_xy.pop_front();
				if (m_tdata[15:0] !== oldest_xy.x)
					report_mismatch("x_component", $signed(m_tdata[15:0]), oldest_xy.x);
				if (m_tdata[31:16] !== oldest_xy.y)
					report_mismatch("y_component", $signed(m_tdata[31:16]), oldest_xy.y);
			end
			results_seen++;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("polar_to_cartesian_degrees_core test failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// receiver: random back-pressure, or one long hold-off on request
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin : stimulus
		xy_t want;
		clk           = 1'b0;
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		mismatches    = 0;
		results_seen  = 0;
		idle_cycles   = 0;
		hold_req      = 1'b0;
		send_idle_pct = 30;
		recv_idle_pct = 47;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int r = 0; r < $size(directed_rows); r++) begin
			if (directed_rows[r].typed) begin
				want.x = directed_rows[r].x;
				want.y = directed_rows[r].y;
			end else begin
				want = polar_to_xy(directed_rows[r].mag, directed_rows[r].ang);
			end
			offer_request(directed_rows[r].mag, directed_rows[r].ang, want);
		end

		for (int phase = 0; phase < 3; phase++) begin
			// sender pauses until the pipeline has drained
			s_tvalid <= 1'b0;
			while (pending_xy.size() != 0)
				@(negedge clk);
			case (phase)
				0: begin
					send_idle_pct = 30;
					recv_idle_pct = 47;
				end
				1: begin
					send_idle_pct = 47;
					recv_idle_pct = 30;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
					hold_req      = 1'b1;   // sender keeps offering into a blocked output
				end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				logic signed [15:0] mag;
				logic signed [16:0] ang;
				mag = pick_magnitude();
				ang = pick_angle();
				offer_request(mag, ang, polar_to_xy(mag, ang));
			end
		end
		s_tvalid <= 1'b0;

		while (pending_xy.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (mismatches == 0)
			$display("polar_to_cartesian_degrees_core test passed");
		else
			$display("polar_to_cartesian_degrees_core test failed");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/p2cd_pkg.sv
hdl/polar_to_cartesian_degrees_core.sv
tb/tb_polar_to_cartesian_degrees_core.sv
